/* hdl/sdx_pkg.sv */
// Shared types, constants and the letter class table of the Soundex encoder.
// No dependencies; the design modules refer to it by scoped names.
package sdx_pkg;

  localparam int CodeDigits = 3;
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = 1;
  localparam int QueueCntW  = 2;

  localparam logic [2:0] CLASS_NONE = 3'd0;
  localparam logic [2:0] CLASS_LABIAL = 3'd1;
  localparam logic [2:0] CLASS_SIBILANT = 3'd2;
  localparam logic [2:0] CLASS_DENTAL = 3'd3;
  localparam logic [2:0] CLASS_LATERAL = 3'd4;
  localparam logic [2:0] CLASS_NASAL = 3'd5;
  localparam logic [2:0] CLASS_RHOTIC = 3'd6;

  typedef logic [2:0] class_t;

  // One classified byte as it travels from the front to the back.
  typedef struct packed {
    logic [7:0] letter;
    class_t     cls;
    logic       last;
  } entry_t;

  function automatic logic [7:0] upper_of(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c inside {["a":"z"]}) begin
      r = c & 8'hDF;
    end
    return r;
  endfunction

  function automatic class_t class_of(input logic [7:0] c);
    logic [7:0] lc;
    class_t     k;
    lc = c;
    k  = CLASS_NONE;
    if (c inside {["A":"Z"]}) begin
      lc = c | 8'h20;
    end
    if (lc inside {"b", "f", "p", "v"}) begin
      k = CLASS_LABIAL;
    end else if (lc inside {"c", "g", "j", "k", "q", "s", "x", "z"}) begin
      k = CLASS_SIBILANT;
    end else if (lc inside {"d", "t"}) begin
      k = CLASS_DENTAL;
    end else if (lc == "l") begin
      k = CLASS_LATERAL;
    end else if (lc inside {"m", "n"}) begin
      k = CLASS_NASAL;
    end else if (lc == "r") begin
      k = CLASS_RHOTIC;
    end
    return k;
  endfunction

endpackage

/* hdl/sdx_char_if.sv */
// Input channel of the Soundex encoder: one byte of a word per request.
// Depends on nothing.
interface sdx_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last_of_word;

  modport source (output valid, character, last_of_word, input ready);
  modport sink (input valid, character, last_of_word, output ready);
endinterface

/* hdl/sdx_code_if.sv */
// Output channel of the Soundex encoder: one finished code per request.
// Depends on nothing.
interface sdx_code_if;
  logic       valid;
  logic       ready;
  logic [7:0] first_letter;
  logic [2:0] digit_one;
  logic [2:0] digit_two;
  logic [2:0] digit_three;

  modport source (output valid, first_letter, digit_one, digit_two, digit_three,
                  input ready);
  modport sink (input valid, first_letter, digit_one, digit_two, digit_three,
                output ready);
endinterface

/* hdl/sdx_front.sv */
// Front end: accepts bytes, upper-cases and classifies them for the queue.
// Depends on sdx_pkg and sdx_char_if.
module sdx_front (
  sdx_char_if.sink        chars,
  output logic            push_valid,
  output sdx_pkg::entry_t push_ent,
  input  logic            push_ready
);

  assign chars.ready     = push_ready;
  assign push_valid      = chars.valid;
  assign push_ent.letter = sdx_pkg::upper_of(chars.character);
  assign push_ent.cls    = sdx_pkg::class_of(chars.character);
  assign push_ent.last   = chars.last_of_word;

endmodule

/* hdl/sdx_queue.sv */
// Two-entry queue of classified bytes between the front and the back.
// Depends on sdx_pkg.
module sdx_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  input  sdx_pkg::entry_t push_ent,
  output logic            push_ready,
  output logic            pop_valid,
  output sdx_pkg::entry_t pop_ent,
  input  logic            pop_ready
);

  sdx_pkg::entry_t                   slots [sdx_pkg::QueueDepth];
  logic [sdx_pkg::QueuePtrW-1:0]     wr_ptr;
  logic [sdx_pkg::QueuePtrW-1:0]     rd_ptr;
  logic [sdx_pkg::QueueCntW-1:0]     count;
  logic                              push;
  logic                              pop;

  assign push_ready = (count != sdx_pkg::QueueCntW'(sdx_pkg::QueueDepth));
  assign pop_valid  = (count != '0);
  assign pop_ent    = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + sdx_pkg::QueueCntW'(1);
      end else if (pop && !push) begin
        count <= count - sdx_pkg::QueueCntW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= sdx_pkg::QueueCntW'(sdx_pkg::QueueDepth))
    else $error("queue count beyond depth");

endmodule

/* hdl/sdx_back.sv */
// Back end: builds the code of each word and holds it in the output register.
// Depends on sdx_pkg and sdx_code_if.
module sdx_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            pop_valid,
  input  sdx_pkg::entry_t pop_ent,
  output logic            pop_ready,
  sdx_code_if.source      codes
);

  logic                  inside_word;
  logic [7:0]            kept_first;
  sdx_pkg::class_t       previous_class;
  logic [1:0]            held_count;
  sdx_pkg::class_t       held_digits [sdx_pkg::CodeDigits];

  logic                  inside_word_next;
  logic [7:0]            kept_first_next;
  sdx_pkg::class_t       previous_class_next;
  logic [1:0]            held_count_next;
  sdx_pkg::class_t       held_digits_next [sdx_pkg::CodeDigits];

  logic                  code_valid;
  logic                  pop;
  logic                  emit;

  // A word end needs the output register free (or emptied this cycle).
  assign pop_ready = !pop_ent.last || !code_valid || codes.ready;
  assign pop       = pop_valid && pop_ready;
  assign emit      = pop && pop_ent.last;

  always_comb begin
    inside_word_next    = inside_word;
    kept_first_next     = kept_first;
    previous_class_next = previous_class;
    held_count_next     = held_count;
    held_digits_next    = held_digits;
    if (!inside_word) begin
      kept_first_next     = pop_ent.letter;
      previous_class_next = pop_ent.cls;
      held_count_next     = '0;
      inside_word_next    = 1'b1;
    end else if (held_count != 2'(sdx_pkg::CodeDigits)) begin
      if (pop_ent.cls != sdx_pkg::CLASS_NONE && pop_ent.cls != previous_class) begin
        held_digits_next[held_count] = pop_ent.cls;
        held_count_next              = held_count + 2'd1;
        previous_class_next          = pop_ent.cls;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_word    <= 1'b0;
      kept_first     <= '0;
      previous_class <= sdx_pkg::CLASS_NONE;
      held_count     <= '0;
      held_digits    <= '{default: sdx_pkg::CLASS_NONE};
    end else if (pop) begin
      if (pop_ent.last) begin
        inside_word    <= 1'b0;
        kept_first     <= '0;
        previous_class <= sdx_pkg::CLASS_NONE;
        held_count     <= '0;
        held_digits    <= '{default: sdx_pkg::CLASS_NONE};
      end else begin
        inside_word    <= inside_word_next;
        kept_first     <= kept_first_next;
        previous_class <= previous_class_next;
        held_count     <= held_count_next;
        held_digits    <= held_digits_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_valid <= 1'b0;
    end else if (emit) begin
      code_valid <= 1'b1;
    end else if (codes.ready) begin
      code_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      codes.first_letter <= kept_first_next;
      codes.digit_one    <= held_digits_next[0];
      codes.digit_two    <= held_digits_next[1];
      codes.digit_three  <= held_digits_next[2];
    end
  end

  assign codes.valid = code_valid;

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    emit |=> code_valid)
    else $error("word end did not load the output register");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    emit |=> !inside_word && held_count == 2'd0)
    else $error("word state not cleared after a word end");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    code_valid && !codes.ready |-> !emit)
    else $error("pending code overwritten");

  a_unused_digit_zero: assert property (@(posedge clk) disable iff (rst)
    held_count != 2'd3 |-> held_digits[2] == sdx_pkg::CLASS_NONE)
    else $error("third digit set before three were held");

endmodule

/* hdl/soundex_word_encoder_core.sv */
// Top level of the Soundex word encoder: front end, queue and back end.
// Depends on sdx_pkg, sdx_char_if, sdx_code_if, sdx_front, sdx_queue, sdx_back.
//
//   Channel  Direction  Request carries
//   chars    in         character (8 bits), last_of_word (1 bit)
//   codes    out        first_letter (8), digit_one/two/three (3 bits each)
//
// A byte is taken every cycle while the queue has room; its code digit is
// folded into the word state once the queue hands it to the back end, so a
// stream moves at one byte per cycle. The last byte of a word passes through
// the two-entry queue and then the output register on its way to its code.
// Reset (rst, synchronous) empties the queue and the output register and
// starts a new word. When codes is stalled, the back end keeps taking bytes
// until it meets the next word end, and the queue then backs up into chars.

module soundex_word_encoder_core (
  input logic        clk,
  input logic        rst,
  sdx_char_if.sink   chars,
  sdx_code_if.source codes
);

  // Front-to-queue request.
  logic            push_valid;
  logic            push_ready;
  sdx_pkg::entry_t push_ent;

  // Queue-to-back request.
  logic            pop_valid;
  logic            pop_ready;
  sdx_pkg::entry_t pop_ent;

  // Classification of each byte happens on the way in.
  sdx_front u_front (
    .chars      (chars),
    .push_valid (push_valid),
    .push_ent   (push_ent),
    .push_ready (push_ready)
  );

  // The queue lets the front keep accepting while the back waits on codes.
  sdx_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ent   (push_ent),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_ent    (pop_ent),
    .pop_ready  (pop_ready)
  );

  // The back end owns the word state and the registered result.
  sdx_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ent   (pop_ent),
    .pop_ready (pop_ready),
    .codes     (codes)
  );

endmodule
